FILE: hw/rtl/pyth_pkg.sv
// Shared constants, widths and sequencer states of the Pythagorean sum block.
// Used by pyth_div, pyth_mul and pythagorean_sum_iterative; depends on nothing.
package pyth_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORK_FRAC = 32;
  localparam int MAX_ITER  = 4;

  localparam int LEG_W = 32;
  localparam int MAG_W = 48;
  // Ratio values q, r, u lie in [0, 1.4], so one integer bit is enough.
  localparam int QW = WORK_FRAC + 1;
  // The divisor r + 4 stays at or below 5, and min/max takes a 32-bit leg.
  localparam int DW = (WORK_FRAC + 3 > LEG_W) ? WORK_FRAC + 3 : LEG_W;
  // Magnitude accumulator, kept at 64 bits like the product it comes from.
  localparam int PW = 64;
  localparam int MW = PW + QW;
  localparam int DIV_STEPS = WORK_FRAC + 1;
  localparam int MUL_STEPS = QW;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam int ITER_W = $clog2(MAX_ITER + 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_Q0   = 10'b0000000010,
    ST_R0   = 10'b0000000100,
    ST_CHK  = 10'b0000001000,
    ST_S    = 10'b0000010000,
    ST_P    = 10'b0000100000,
    ST_Q    = 10'b0001000000,
    ST_QQ   = 10'b0010000000,
    ST_R    = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } state_t;

endpackage

FILE: hw/rtl/pyth_div.sv
// Restoring fractional divider: floor(num * 2^WORK_FRAC / den), one bit a cycle.
// Depends on pyth_pkg.
module pyth_div import pyth_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          done,
  output logic          busy
);

  logic [DW:0]    rem;
  logic [DW-1:0]  den_r;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]    trial;
  logic           fits;

  // The first step compares the numerator itself; later steps shift first.
  assign trial = (cnt == '0) ? rem : {rem[DW-1:0], 1'b0};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_r <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, den_r}) : trial;
      quo <= {quo[QW-2:0], fits};
    end
  end

endmodule

FILE: hw/rtl/pyth_mul.sv
// Shift-and-add multiplier: (a * b) >> WORK_FRAC, kept to 64 bits, one bit of b
// a cycle, most significant first. Depends on pyth_pkg.
module pyth_mul import pyth_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] a,
  input  logic [QW-1:0] b,
  output logic [PW-1:0] res,
  output logic          done,
  output logic          busy
);

  logic [MW-1:0]    acc;
  logic [PW-1:0]    a_r;
  logic [QW-1:0]    b_r;
  logic [CNT_W-1:0] cnt;

  assign res = acc[WORK_FRAC +: PW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      acc <= {acc[MW-2:0], 1'b0} + (b_r[QW-1] ? MW'(a_r) : MW'(0));
      b_r <= {b_r[QW-2:0], 1'b0};
    end
  end

endmodule

FILE: hw/rtl/pythagorean_sum_iterative.sv
// Top level of the Pythagorean sum block (Moler-Morrison iteration).
// Depends on pyth_pkg, pyth_div and pyth_mul.
//
//   channel | ports                         | direction
//   input   | in_valid, in_stall, x_value,  | word in, stall out
//           | y_value                       |
//   output  | out_valid, out_stall,         | word out, stall in
//           | magnitude                     |
//
// The serial divider and multiplier each take WORK_FRAC + 1 steps per operation
// and run one after the other under the sequencer; a round is five operations
// and a check. A zero pair skips every round and goes straight to the finish
// state. Reset (rst, synchronous) returns the sequencer to idle and drops
// out_valid. in_stall is high from acceptance until the result is loaded into
// the output register; a stalled result is held there and the next input word
// can be accepted meanwhile.
module pythagorean_sum_iterative import pyth_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [LEG_W-1:0] x_value,
  input  logic signed [LEG_W-1:0] y_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [MAG_W-1:0]        magnitude
);

  localparam logic [QW-1:0] ONE  = QW'(1) << WORK_FRAC;
  localparam logic [DW-1:0] FOUR = DW'(1) << (WORK_FRAC + 2);

  state_t state, state_next;

  logic [PW-1:0]     p;
  logic [QW-1:0]     r;
  logic [QW-1:0]     s;
  logic [QW-1:0]     u;
  logic [ITER_W-1:0] iter;

  logic [LEG_W-1:0] ax, ay, big, small_leg;
  logic             accept;

  // Shared arithmetic units and their operand selection.
  logic          div_start, div_done, div_busy;
  logic [DW-1:0] div_num, div_den;
  logic [QW-1:0] div_quo;
  logic          mul_start, mul_done, mul_busy;
  logic [PW-1:0] mul_a, mul_res;
  logic [QW-1:0] mul_b;
  logic [QW-1:0] u_new;

  // Absolute values; the most negative leg maps onto 2^31 unchanged.
  assign ax = x_value[LEG_W-1] ? (LEG_W'(0) - x_value) : x_value;
  assign ay = y_value[LEG_W-1] ? (LEG_W'(0) - y_value) : y_value;
  assign big       = (ax > ay) ? ax : ay;
  assign small_leg = (ax > ay) ? ay : ax;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // u = 2s + 1, formed straight from the divider output.
  assign u_new = {div_quo[QW-2:0], 1'b0} + ONE;

  pyth_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done),
    .busy (div_busy)
  );

  pyth_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .res  (mul_res),
    .done (mul_done),
    .busy (mul_busy)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = DW'(small_leg);
    div_den    = DW'(big);
    mul_start  = 1'b0;
    mul_a      = PW'(div_quo);
    mul_b      = div_quo;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // A zero pair skips every round and returns zero.
          div_start  = (big != '0);
          state_next = (big != '0) ? ST_Q0 : ST_FIN;
        end
      end
      ST_Q0: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = ST_R0;
        end
      end
      ST_R0: begin
        if (mul_done) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (r == '0 || iter == ITER_W'(MAX_ITER)) begin
          state_next = ST_FIN;
        end else begin
          div_start  = 1'b1;
          div_num    = DW'(r);
          div_den    = DW'(r) + FOUR;
          state_next = ST_S;
        end
      end
      ST_S: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_a      = p;
          mul_b      = u_new;
          state_next = ST_P;
        end
      end
      ST_P: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_num    = DW'(s);
          div_den    = DW'(u);
          state_next = ST_Q;
        end
      end
      ST_Q: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = ST_QQ;
        end
      end
      ST_QQ: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = mul_res;
          mul_b      = r;
          state_next = ST_R;
        end
      end
      ST_R: begin
        if (mul_done) begin
          state_next = ST_CHK;
        end
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      iter      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        iter <= '0;
      end else if (state == ST_R && mul_done) begin
        iter <= iter + 1'b1;
      end
    end
  end

  // Datapath registers of the recurrence. The ratio q goes straight from the
  // divider into the multiplier, so it needs no register of its own.
  always_ff @(posedge clk) begin
    if (accept) begin
      p <= PW'(big) << FRAC_BITS;
    end
    if ((state == ST_R0 || state == ST_R) && mul_done) begin
      r <= mul_res[QW-1:0];
    end
    if (state == ST_S && div_done) begin
      s <= div_quo;
      u <= u_new;
    end
    if (state == ST_P && mul_done) begin
      p <= mul_res;
    end
    // A magnitude beyond the output width saturates to all ones.
    if (state == ST_FIN && (!out_valid || !out_stall)) begin
      magnitude <= (p[PW-1:MAG_W] != '0) ? '1 : p[MAG_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // The two shared units never run at the same time.
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_busy && mul_busy))
    else $error("divider and multiplier busy together");

  // The round count never passes its limit.
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= ITER_W'(MAX_ITER))
    else $error("round counter beyond limit");

  // An accepted word keeps the input side stalled in the next cycle.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after acceptance");

  // A stalled result is never overwritten by the sequencer.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude))
    else $error("stalled result changed");
`endif

endmodule

FILE: verif/tb_pythagorean_sum_iterative.sv
// Self-checking testbench for pythagorean_sum_iterative, the fixed-point hypotenuse.
// Depends on pyth_pkg and the block's RTL; needs no files or arguments at run time.
`timescale 1ns / 1ps

module tb_pythagorean_sum_iterative;
  import pyth_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [LEG_W-1:0] x_value = '0;
  logic signed [LEG_W-1:0] y_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [MAG_W-1:0]        magnitude;

  pythagorean_sum_iterative uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_value(x_value), .y_value(y_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .magnitude(magnitude)
  );

  always #5 clk = ~clk;

  // Expected magnitudes, oldest first.
  logic [MAG_W-1:0] pending_mags[$];
  int error_count = 0;
  int words_sent = 0;
  int mags_seen = 0;
  longint unsigned cycle_count = 0;
  // Idle and stall odds in percent; the current phase sets them.
  int send_gap_pct = 0;
  int stall_pct = 0;

  // Product at full width, then the low WORK_FRAC bits dropped.
  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = a * b;
    return prod[WORK_FRAC +: 64];
  endfunction

  // Truncated fraction num / den with WORK_FRAC fraction bits, num <= den.
  function automatic logic [63:0] fix_div(logic [63:0] num, logic [63:0] den);
    logic [127:0] wide;
    if (den == 0) return '0;
    wide = {64'd0, num} << WORK_FRAC;
    return 64'(wide / den);
  endfunction

  function automatic logic [31:0] leg_mag(logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  // Predicted hypotenuse of one pair of legs.
  function automatic logic [MAG_W-1:0] hypot_of(logic [31:0] xv, logic [31:0] yv);
    logic [31:0] ax, ay, big, lil;
    logic [63:0] one, p, q, r, s, u;
    ax = leg_mag(xv);
    ay = leg_mag(yv);
    big = (ax > ay) ? ax : ay;
    lil = (ax > ay) ? ay : ax;
    one = 64'd1 << WORK_FRAC;
    if (big == 0) return '0;
    p = {32'd0, big} << FRAC_BITS;
    q = fix_div({32'd0, lil}, {32'd0, big});
    r = fix_mul(q, q);
    for (int k = 0; k < MAX_ITER; k++) begin
      if (r == 0) break;
      s = fix_div(r, r + (one << 2));
      u = (s << 1) + one;
      p = fix_mul(u, p);
      q = fix_div(s, u);
      r = fix_mul(fix_mul(q, q), r);
    end
    return (p > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : p[MAG_W-1:0];
  endfunction

  // Sends one word after a random gap, holding it steady until accepted.
  // Valid stays high into the next word when no gap follows.
  task automatic send_legs(logic [31:0] xv, logic [31:0] yv);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    x_value <= xv;
    y_value <= yv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_mags.push_back(hypot_of(xv, yv));
    words_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stall driven on the falling edge.
  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      mags_seen++;
      if (pending_mags.size() == 0) begin
        $error("magnitude: unexpected word, actual %0h", magnitude);
        error_count++;
      end else begin
        logic [MAG_W-1:0] want;
        want = pending_mags.pop_front();
        if (magnitude !== want) begin
          $error("magnitude: expected %0h actual %0h", want, magnitude);
          error_count++;
        end
      end
    end
  end

  // This limit covers every phase several times over.
  always @(posedge clk) begin
    if (cycle_count > 2_000_000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_mags.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // Edges of the legs, equal legs, zero pairs and the most negative value.
  task automatic test_directed();
    logic [31:0] edges[8];
    edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'd3, 32'd4, 32'hAAAA_5555};
    send_legs(0, 0);
    send_legs(32'd3, 32'd4);
    send_legs(32'h8000_0000, 32'h8000_0000);
    send_legs(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_legs(32'h8000_0000, 0);
    send_legs(0, 32'h8000_0001);
    send_legs(32'd5, 32'hFFFF_FFFB);
    for (int i = 0; i < 16; i++) send_legs(edges[i % 8], edges[(i * 3 + 1) % 8]);
    drain();
  endtask

  // Random legs of mixed scale: full range, small, equal and one-zero pairs.
  task automatic test_random(int count, int gap, int stall);
    logic [31:0] xv, yv;
    send_gap_pct = gap;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      xv = $urandom();
      yv = $urandom();
      case ($urandom_range(5))
        0: begin
          xv = $signed(xv) >>> $urandom_range(31);
          yv = $signed(yv) >>> $urandom_range(31);
        end
        1: yv = $urandom_range(1) ? xv : 32'd0 - xv;
        2: yv = 0;
        3: yv = $signed(xv) >>> $urandom_range(31);
        default: ;
      endcase
      send_legs(xv, yv);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 48, 0);
    test_random(100, 0, 48);
    test_random(100, 34, 34);
    // Summary of what was exercised.
    $display("Sent %0d leg pairs, checked %0d magnitudes across four idle/stall phases.",
             words_sent, mags_seen);
    if (error_count == 0 && pending_mags.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pyth_pkg.sv
hw/rtl/pyth_div.sv
hw/rtl/pyth_mul.sv
hw/rtl/pythagorean_sum_iterative.sv
verif/tb_pythagorean_sum_iterative.sv
